/* rtl/core/led_status_brightness_animator_core_assert.svh */
// assertion macros for the led status brightness animator core
// used by the core module, no other dependencies
`ifndef LED_STATUS_BRIGHTNESS_ANIMATOR_CORE_ASSERT_SVH
`define LED_STATUS_BRIGHTNESS_ANIMATOR_CORE_ASSERT_SVH

// same-cycle implication, gated by reset
`define LSBA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsba assertion failed");

// next-cycle implication, gated by reset
`define LSBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsba assertion failed");

`endif

/* rtl/core/lsba_pkg.sv */
// types and constants for the led status brightness animator
// no dependencies
`timescale 1ns / 1ps

package lsba_pkg;

  localparam int unsigned CHANNELS = 4;

  localparam logic [7:0]  STARTUP_RAMP      = 8'd200;
  localparam logic [8:0]  STARTUP_STAGGER   = 9'd100;
  localparam logic [10:0] STARTUP_LAST_RAMP = 11'd5;
  localparam logic [7:0]  BOOT_RAMP         = 8'd142;
  localparam logic [31:0] MOVE_WINDOW       = 32'd100;
  localparam logic [31:0] SETTLE_TIME       = 32'd1100;
  localparam logic [6:0]  BLINK_PERIOD      = 7'd100;
  localparam logic [6:0]  BLINK_HALF        = 7'd50;
  localparam logic [7:0]  FULL_ON           = 8'd255;
  localparam logic [7:0]  DIMMED            = 8'd127;
  localparam logic [15:0] ANIM_RESET        = 16'd2000;

  // reciprocal constants for division by fixed divisors
  localparam logic [24:0] RECIP_BOOT  = 25'd30246248; // floor(2^32 / 142)
  localparam logic [14:0] RECIP_25    = 15'd5243;     // 2^17 / 25, rounded up
  localparam logic [14:0] RECIP_71    = 15'd29538;    // 2^21 / 71, rounded up
  localparam logic [21:0] RECIP_BLINK = 22'd2684355;  // 2^28 / 100, rounded up
  localparam logic [5:0]  HI_WEIGHT   = 6'd36;        // 2^16 mod 100

  // register select, byte address bit 2
  localparam logic REG_STARTUP = 1'b0;
  localparam logic REG_ANIM    = 1'b1;

  typedef enum logic [2:0] {
    MODE_OFF,
    MODE_STARTUP,
    MODE_BOOT,
    MODE_BLINK,
    MODE_FULL
  } lsba_mode_t;

  typedef struct packed {
    logic [1:0]  channel;
    logic [31:0] now_ms;
    logic        waiting_for_startup;
    logic        connected;
    logic [31:0] detection_time_ms;
    logic [31:0] last_move_time_ms;
  } lsba_req_t;

  typedef struct packed {
    logic [1:0] out_channel;
    logic [7:0] brightness;
  } lsba_res_t;

  typedef struct packed {
    logic [1:0]  channel;
    lsba_mode_t  mode;
    logic [15:0] t;
    logic [2:0]  sk;
    logic [31:0] d;
    logic [24:0] bq0;
    logic [21:0] nx;
  } lsba_s2_t;

  typedef struct packed {
    logic [1:0]  channel;
    lsba_mode_t  mode;
    logic [7:0]  tri_val;
    logic [21:0] nx;
    logic [14:0] bk;
  } lsba_s3_t;

endpackage

/* rtl/core/lsba_if.sv */
// request and result channels of the led status brightness animator
// depends on lsba_pkg
`timescale 1ns / 1ps

interface lsba_req_if;
  import lsba_pkg::*;
  logic      valid;
  logic      ready;
  lsba_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsba_res_if;
  import lsba_pkg::*;
  logic      valid;
  logic      ready;
  lsba_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/led_status_brightness_animator_core.sv */
// led status brightness animator, four-register pipeline with apb config
// depends on lsba_pkg, lsba_if and led_status_brightness_animator_core_assert.svh
`timescale 1ns / 1ps

// Each request item gives one channel's LED brightness. The core takes one item per clock
// when no stage stalls and returns its result through four register levels (input,
// quotient, triangle, result) that stall together only where a stage is full and the one
// after it cannot move. Two registers sit on the APB port: startup_time_ms at byte address
// 0 and animation_time_ms at byte address 4 (reset 0 and 2000).
module led_status_brightness_animator_core (
  input  logic        clk,
  input  logic        rst,
  lsba_req_if.sink    req,
  lsba_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lsba_pkg::*;

  `include "led_status_brightness_animator_core_assert.svh"

  logic [31:0] startup_time_ms;
  logic [15:0] animation_time_ms;

  logic      v1, v2, v3, v4;
  logic      adv1, adv2, adv3, adv4;
  lsba_req_t s1;
  lsba_s2_t  s2, s2_next;
  lsba_s3_t  s3, s3_next;
  lsba_res_t s4, s4_next;

  // stage a signals
  logic        ch_ok;
  logic [31:0] e;
  logic        in_window;
  logic [8:0]  delay;
  logic        early;
  logic [15:0] t16;
  logic [27:0] sk_prod;
  logic [10:0] sk;
  logic [31:0] d;
  logic [56:0] bq_prod;
  logic        settled;
  logic        recent;
  logic [21:0] nx;

  // stage b signals
  logic [15:0] sr;
  logic [7:0]  tri_s;
  logic [31:0] br0;
  logic        wrap;
  logic [8:0]  br9;
  logic [7:0]  br;
  logic        par;
  logic [7:0]  tri_b;
  logic [43:0] bk_prod;

  // stage c signals
  logic [15:0] y;
  logic [14:0] mx;
  logic [14:0] mc;
  logic [29:0] sc_prod;
  logic [7:0]  scaled;
  logic [21:0] blink_r;
  logic [7:0]  blink_b;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_time_ms   <= '0;
      animation_time_ms <= ANIM_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_STARTUP: startup_time_ms <= pwdata;
        REG_ANIM:    animation_time_ms <= pwdata[15:0];
        default:     startup_time_ms <= startup_time_ms;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STARTUP: prdata = startup_time_ms;
      REG_ANIM:    prdata = {16'd0, animation_time_ms};
      default:     prdata = '0;
    endcase
  end

  // handshake
  assign adv4      = !v4 || res.ready;
  assign adv3      = !v3 || adv4;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req.ready = adv1;
  assign res.valid = v4;
  assign res.data  = s4;

  // stage a: window, quotient estimates, blink fold
  always_comb begin
    ch_ok     = 32'(s1.channel) < CHANNELS;
    e         = s1.now_ms - startup_time_ms;
    in_window = e < {16'd0, animation_time_ms};
    delay     = 9'(s1.channel) * STARTUP_STAGGER;
    early     = e < {23'd0, delay};
    t16       = e[15:0] - {7'd0, delay};
    sk_prod   = 28'(t16[15:3]) * 28'(RECIP_25);
    sk        = sk_prod[27:17];
    d         = s1.now_ms - s1.detection_time_ms;
    bq_prod   = 57'(d) * 57'(RECIP_BOOT);
    settled   = d > SETTLE_TIME;
    recent    = (s1.now_ms - s1.last_move_time_ms) < MOVE_WINDOW;
    nx        = 22'(s1.now_ms[31:16]) * 22'(HI_WEIGHT) + 22'(s1.now_ms[15:0]);

    s2_next.channel = s1.channel;
    s2_next.t       = t16;
    s2_next.sk      = sk[2:0];
    s2_next.d       = d;
    s2_next.bq0     = bq_prod[56:32];
    s2_next.nx      = nx;
    priority if (!ch_ok) begin
      s2_next.mode = MODE_OFF;
    end else if (in_window) begin
      s2_next.mode = (early || sk > STARTUP_LAST_RAMP) ? MODE_OFF : MODE_STARTUP;
    end else if (s1.waiting_for_startup) begin
      s2_next.mode = MODE_BOOT;
    end else if (s1.connected) begin
      s2_next.mode = (recent && settled) ? MODE_BLINK : MODE_FULL;
    end else begin
      s2_next.mode = MODE_OFF;
    end
  end

  // stage b: remainders and triangle values
  always_comb begin
    sr      = s2.t - 16'(s2.sk) * 16'(STARTUP_RAMP);
    tri_s   = s2.sk[0] ? STARTUP_RAMP - sr[7:0] : sr[7:0];
    br0     = s2.d - 32'(s2.bq0) * 32'(BOOT_RAMP);
    wrap    = br0[8:0] >= 9'(BOOT_RAMP);
    br9     = wrap ? br0[8:0] - 9'(BOOT_RAMP) : br0[8:0];
    br      = br9[7:0];
    par     = s2.bq0[0] ^ wrap;
    tri_b   = par ? BOOT_RAMP - br : br;
    bk_prod = 44'(s2.nx) * 44'(RECIP_BLINK);

    s3_next.channel = s2.channel;
    s3_next.mode    = s2.mode;
    s3_next.nx      = s2.nx;
    s3_next.bk      = bk_prod[42:28];
    unique case (s2.mode)
      MODE_STARTUP: s3_next.tri_val = tri_s;
      MODE_BOOT:    s3_next.tri_val = tri_b;
      default:      s3_next.tri_val = '0;
    endcase
  end

  // stage c: scaling and blink phase
  always_comb begin
    y       = {s3.tri_val, 8'd0} - {8'd0, s3.tri_val};
    mx      = (s3.mode == MODE_STARTUP) ? 15'(y[15:3]) : y[15:1];
    mc      = (s3.mode == MODE_STARTUP) ? RECIP_25 : RECIP_71;
    sc_prod = 30'(mx) * 30'(mc);
    scaled  = (s3.mode == MODE_STARTUP) ? sc_prod[24:17] : sc_prod[28:21];
    blink_r = s3.nx - 22'(s3.bk) * 22'(BLINK_PERIOD);
    blink_b = (blink_r[6:0] < BLINK_HALF) ? FULL_ON : DIMMED;

    s4_next.out_channel = s3.channel;
    unique case (s3.mode)
      MODE_STARTUP: s4_next.brightness = scaled;
      MODE_BOOT:    s4_next.brightness = scaled;
      MODE_BLINK:   s4_next.brightness = blink_b;
      MODE_FULL:    s4_next.brightness = FULL_ON;
      default:      s4_next.brightness = '0;
    endcase
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= req.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1 <= req.data;
    if (adv2) s2 <= s2_next;
    if (adv3) s3 <= s3_next;
    if (adv4) s4 <= s4_next;
  end

  `LSBA_ASSERT_NOW(a_boot_rem, clk, rst, v2 && s2.mode == MODE_BOOT, br9 < 9'(BOOT_RAMP))
  `LSBA_ASSERT_NOW(a_startup_tri, clk, rst, v2 && s2.mode == MODE_STARTUP, tri_s <= STARTUP_RAMP)
  `LSBA_ASSERT_NOW(a_blink_rem, clk, rst, v3 && s3.mode == MODE_BLINK, blink_r < 22'(BLINK_PERIOD))
  `LSBA_ASSERT_NEXT(a_off_dark, clk, rst, v3 && adv4 && s3.mode == MODE_OFF, s4.brightness == 8'd0)

endmodule
